### src/lrc_pkg.sv
`default_nettype none
package lrc_pkg;

    localparam int MAX_LABELS = 64;
    localparam int LABEL_AW   = 6;
    localparam int XY_BITS    = 10;
    localparam int Z_BITS     = 6;

    localparam int VAL_W      = 16;
    localparam int LABEL_W    = 7;
    localparam int TOTAL_W    = 42;
    localparam int SUMZ_W     = 48;
    localparam int SUMXY_W    = 52;
    localparam int CZ_W       = 14;
    localparam int CXY_W      = 18;

    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 104;
    localparam int PADDR_W    = 3;

    // quotient bits per division, one more than the widest centroid
    localparam int QUOT_W     = CXY_W + 1;
    localparam int REM_W      = SUMXY_W + 8 + 2;

    // one table entry: moments of one label
    typedef struct packed {
        logic [SUMXY_W-1:0] sum_x;
        logic [SUMXY_W-1:0] sum_y;
        logic [SUMZ_W-1:0]  sum_z;
        logic [TOTAL_W-1:0] total;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

### src/lrc_ram.sv
`default_nettype none
module lrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### src/labeled_region_centroids.sv
// Voxel: accepted in idle, table entry read, then written back the next cycle;
//   a new voxel is taken only once back in idle, after the table read-modify-write.
// Readout after the last voxel: per label a read, a latch, then per centroid a load
//   and 19 divide steps, then the output handshake; no voxel taken meanwhile.
// Reset (aresetn low, synchronous): table cleared at once through per-entry valid
//   bits, label_count zero, both channels idle. Valid bits also clear after readout.
`default_nettype none
module labeled_region_centroids (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // {x_pos, y_pos, z_pos, voxel_label, voxel_value}, voxel_value at bit 0
    input  wire logic [lrc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tlast,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // {centroid_x, centroid_y, centroid_z, total_intensity, region_index}, index at bit 0
    output logic      [lrc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lrc_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);
    import lrc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ACC, ST_RD, ST_LATCH, ST_DLOAD, ST_DSTEP, ST_OUT
    } state_t;

    state_t                  state_reg;
    logic [LABEL_W-1:0]      label_count_reg;
    logic [MAX_LABELS-1:0]   valid_reg;
    logic                    valid_rd_reg;

    // captured voxel
    logic [VAL_W-1:0]        val_reg;
    logic [Z_BITS-1:0]       z_reg;
    logic [XY_BITS-1:0]      y_reg;
    logic [XY_BITS-1:0]      x_reg;
    logic [LABEL_AW-1:0]     addr_reg;
    logic                    hit_reg;
    logic                    last_reg;

    // readout
    logic [LABEL_AW-1:0]     idx_reg;
    entry_t                  ent_reg;
    logic [1:0]              sel_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [REM_W-1:0]        dsr_reg;
    logic [QUOT_W-1:0]       q_reg;
    logic [4:0]              step_reg;
    logic [CZ_W-1:0]         cz_reg;
    logic [CXY_W-1:0]        cy_reg;
    logic [CXY_W-1:0]        cx_reg;

    // ram
    logic                    ram_we;
    logic [LABEL_AW-1:0]     ram_raddr;
    entry_t                  ram_wdata;
    entry_t                  ram_rdata;
    entry_t                  cur;

    lrc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_LABELS)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // input field split
    logic [VAL_W-1:0]   in_val;
    logic [LABEL_W-1:0] in_lab;
    logic [LABEL_W-1:0] in_lab_m1;
    logic [LABEL_W-1:0] n_cnt;
    logic               in_hit;
    logic               s_acc;
    logic               m_acc;

    assign in_val    = s_tdata[15:0];
    assign in_lab    = s_tdata[22:16];
    assign in_lab_m1 = in_lab - LABEL_W'(1);
    assign n_cnt     = (label_count_reg > LABEL_W'(MAX_LABELS)) ?
                       LABEL_W'(MAX_LABELS) : label_count_reg;
    assign in_hit    = (in_lab != '0) && (in_lab <= n_cnt);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;

    assign ram_raddr = (state_reg == ST_IDLE) ? in_lab_m1[LABEL_AW-1:0] : idx_reg;

    // entry not yet written reads as zero
    assign cur = valid_rd_reg ? ram_rdata : '0;

    // saturating accumulate
    logic [VAL_W+Z_BITS-1:0]   prod_z;
    logic [VAL_W+XY_BITS-1:0]  prod_y;
    logic [VAL_W+XY_BITS-1:0]  prod_x;
    logic [TOTAL_W:0]          add_t;
    logic [SUMZ_W:0]           add_z;
    logic [SUMXY_W:0]          add_y;
    logic [SUMXY_W:0]          add_x;

    always_comb begin
        prod_z = (VAL_W+Z_BITS)'(val_reg) * (VAL_W+Z_BITS)'(z_reg);
        prod_y = (VAL_W+XY_BITS)'(val_reg) * (VAL_W+XY_BITS)'(y_reg);
        prod_x = (VAL_W+XY_BITS)'(val_reg) * (VAL_W+XY_BITS)'(x_reg);
        add_t  = (TOTAL_W+1)'(cur.total) + (TOTAL_W+1)'(val_reg);
        add_z  = (SUMZ_W+1)'(cur.sum_z) + (SUMZ_W+1)'(prod_z);
        add_y  = (SUMXY_W+1)'(cur.sum_y) + (SUMXY_W+1)'(prod_y);
        add_x  = (SUMXY_W+1)'(cur.sum_x) + (SUMXY_W+1)'(prod_x);
        ram_wdata.total = add_t[TOTAL_W] ? '1 : add_t[TOTAL_W-1:0];
        ram_wdata.sum_z = add_z[SUMZ_W]  ? '1 : add_z[SUMZ_W-1:0];
        ram_wdata.sum_y = add_y[SUMXY_W] ? '1 : add_y[SUMXY_W-1:0];
        ram_wdata.sum_x = add_x[SUMXY_W] ? '1 : add_x[SUMXY_W-1:0];
        ram_we = (state_reg == ST_ACC) && hit_reg;
    end

    // divider operands: rounded dividend, one restoring step
    logic [REM_W-1:0]  div_num;
    logic [REM_W:0]    trial;
    logic              qbit;
    logic [QUOT_W-1:0] q_fin;
    logic [QUOT_W-1:0] q_max;
    logic [CXY_W-1:0]  q_res;

    always_comb begin
        case (sel_reg)
            2'd0:    div_num = REM_W'({ent_reg.sum_z, 8'd0});
            2'd1:    div_num = REM_W'({ent_reg.sum_y, 8'd0});
            default: div_num = REM_W'({ent_reg.sum_x, 8'd0});
        endcase
        div_num = div_num + REM_W'(ent_reg.total >> 1);
        trial   = {1'b0, rem_reg} - {1'b0, dsr_reg};
        qbit    = !trial[REM_W];
        q_fin   = {q_reg[QUOT_W-2:0], qbit};
        q_max   = (sel_reg == 2'd0) ? QUOT_W'((1 << CZ_W) - 1) : QUOT_W'((1 << CXY_W) - 1);
        if (ent_reg.total == '0) begin
            q_res = '0;
        end else if (q_fin > q_max) begin
            q_res = q_max[CXY_W-1:0];
        end else begin
            q_res = q_fin[CXY_W-1:0];
        end
    end

    // control and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            label_count_reg <= '0;
            valid_reg       <= '0;
            m_tvalid        <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
                label_count_reg <= pwdata[LABEL_W-1:0];
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        val_reg      <= in_val;
                        z_reg        <= s_tdata[28:23];
                        y_reg        <= s_tdata[38:29];
                        x_reg        <= s_tdata[48:39];
                        addr_reg     <= in_lab_m1[LABEL_AW-1:0];
                        hit_reg      <= in_hit;
                        last_reg     <= s_tlast;
                        valid_rd_reg <= valid_reg[in_lab_m1[LABEL_AW-1:0]];
                        state_reg    <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (hit_reg) begin
                        valid_reg[addr_reg] <= 1'b1;
                    end
                    idx_reg <= '0;
                    if (!last_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (n_cnt == '0) begin
                        valid_reg <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    valid_rd_reg <= valid_reg[idx_reg];
                    state_reg    <= ST_LATCH;
                end
                ST_LATCH: begin
                    ent_reg   <= cur;
                    sel_reg   <= 2'd0;
                    state_reg <= ST_DLOAD;
                end
                ST_DLOAD: begin
                    rem_reg   <= div_num;
                    dsr_reg   <= REM_W'(ent_reg.total) << (QUOT_W - 1);
                    q_reg     <= '0;
                    step_reg  <= 5'(QUOT_W - 1);
                    state_reg <= ST_DSTEP;
                end
                ST_DSTEP: begin
                    if (qbit) begin
                        rem_reg <= trial[REM_W-1:0];
                    end
                    dsr_reg  <= dsr_reg >> 1;
                    q_reg    <= q_fin;
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == '0) begin
                        case (sel_reg)
                            2'd0:    cz_reg <= q_res[CZ_W-1:0];
                            2'd1:    cy_reg <= q_res;
                            default: cx_reg <= q_res;
                        endcase
                        if (sel_reg == 2'd2) begin
                            m_tvalid  <= 1'b1;
                            state_reg <= ST_OUT;
                        end else begin
                            sel_reg   <= sel_reg + 2'd1;
                            state_reg <= ST_DLOAD;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_acc) begin
                        m_tvalid <= 1'b0;
                        if (m_tlast) begin
                            valid_reg <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + LABEL_AW'(1);
                            state_reg <= ST_RD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result word
    logic [LABEL_W-1:0] region_index;
    assign region_index = LABEL_W'(idx_reg) + LABEL_W'(1);
    assign m_tlast      = (region_index == n_cnt);
    assign m_tdata      = {5'd0, cx_reg, cy_reg, cz_reg, ent_reg.total, region_index};

    // config read
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(label_count_reg) : 32'd0;

    // checks
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input taken during readout");
    a_wr_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !s_tready) else $error("table write while idle");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_tlast) |=> (valid_reg == '0)) else $error("table not cleared");

endmodule
`default_nettype wire

### sim/tb_labeled_region_centroids.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_labeled_region_centroids;
    import lrc_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_LABEL_COUNT = 3'd0;
    localparam int RANDOM_VOXELS = 420;
    localparam int DRAIN_CYCLES  = 200;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 20000;
    localparam int N_DIR         = 12;

    typedef struct {
        logic [VAL_W-1:0]   value;
        logic [LABEL_W-1:0] label;
        logic [Z_BITS-1:0]  z;
        logic [XY_BITS-1:0] y;
        logic [XY_BITS-1:0] x;
        logic               last;
    } voxel_t;

    typedef struct packed {
        logic [LABEL_W-1:0] index;
        logic [TOTAL_W-1:0] total;
        logic [CZ_W-1:0]    cz;
        logic [CXY_W-1:0]   cy;
        logic [CXY_W-1:0]   cx;
        logic               last;
    } moments_t;

    // directed row: voxel plus a hand-typed result where one is obvious
    typedef struct {
        voxel_t   vox;
        logic     typed;
        moments_t res;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    labeled_region_centroids u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // predictor copy of the moment table and count
    longint unsigned mom_total [MAX_LABELS];
    longint unsigned mom_z [MAX_LABELS];
    longint unsigned mom_y [MAX_LABELS];
    longint unsigned mom_x [MAX_LABELS];
    int unsigned label_cfg = 0;

    moments_t region_q[$];
    int fail_cnt = 0;
    int mism_cnt = 0;
    int voxels_sent = 0;
    int regions_seen = 0;
    int frames_sent = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    bit hold_rx = 1'b0;
    int stall_cycles = 0;

    function automatic longint unsigned sat_add(longint unsigned acc, longint unsigned add,
                                                int w);
        longint unsigned lim, s;
        lim = (64'd1 << w) - 1;
        s = acc + add;
        return (s > lim || s < acc) ? lim : s;
    endfunction

    function automatic longint unsigned centroid_of(longint unsigned sum,
                                                    longint unsigned tot, int w);
        longint unsigned q, lim;
        lim = (64'd1 << w) - 1;
        if (tot == 0) return 0;
        q = ((sum << 8) + (tot >> 1)) / tot;
        return q > lim ? lim : q;
    endfunction

    function automatic void clear_moments();
        for (int i = 0; i < MAX_LABELS; i++) begin
            mom_total[i] = 0; mom_z[i] = 0; mom_y[i] = 0; mom_x[i] = 0;
        end
    endfunction

    // accumulate one voxel; on the last voxel queue the readout
    function automatic void predict_voxel(voxel_t v, bit use_typed, moments_t typed);
        int unsigned n, e;
        moments_t r;
        n = label_cfg > MAX_LABELS ? MAX_LABELS : label_cfg;
        if (v.label != 0 && v.label <= label_cfg && v.label <= MAX_LABELS) begin
            e = v.label - 1;
            mom_total[e] = sat_add(mom_total[e], 64'(v.value), TOTAL_W);
            mom_z[e] = sat_add(mom_z[e], 64'(v.value) * 64'(v.z), SUMZ_W);
            mom_y[e] = sat_add(mom_y[e], 64'(v.value) * 64'(v.y), SUMXY_W);
            mom_x[e] = sat_add(mom_x[e], 64'(v.value) * 64'(v.x), SUMXY_W);
        end
        if (!v.last) return;
        if (use_typed) begin
            region_q.push_back(typed);
        end else begin
            for (int i = 0; i < n; i++) begin
                r.index = LABEL_W'(i + 1);
                r.total = TOTAL_W'(mom_total[i]);
                r.cz = CZ_W'(centroid_of(mom_z[i], mom_total[i], CZ_W));
                r.cy = CXY_W'(centroid_of(mom_y[i], mom_total[i], CXY_W));
                r.cx = CXY_W'(centroid_of(mom_x[i], mom_total[i], CXY_W));
                r.last = (i + 1 == n);
                region_q.push_back(r);
            end
        end
        clear_moments();
    endfunction

    // sender: valid stays high across back-to-back words
    task automatic send_voxel(voxel_t v, bit use_typed = 1'b0, moments_t typed = '{default: 0});
        while (idle_on && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= {7'd0, v.x, v.y, v.z, v.label, v.value};
        s_tlast <= v.last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_voxel(v, use_typed, typed);
        voxels_sent++;
        if (v.last) frames_sent++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until all results are in, then let the block settle
    task automatic drain();
        stop_sending();
        wait (region_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_label_count(int unsigned val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_LABEL_COUNT; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        label_cfg = val & 32'h7f;
        @(posedge aclk);
    endtask

    function automatic voxel_t rand_voxel(bit in_range);
        voxel_t v;
        v.value = VAL_W'($urandom);
        v.z = Z_BITS'($urandom);
        v.y = XY_BITS'($urandom);
        v.x = XY_BITS'($urandom);
        v.last = 1'b0;
        if (in_range && label_cfg > 0)
            v.label = LABEL_W'($urandom_range(label_cfg > MAX_LABELS ? MAX_LABELS : label_cfg,
                                              1));
        else
            v.label = LABEL_W'($urandom_range(127, 0));
        // some small intensities so rounding is exercised
        if ($urandom_range(3) == 0) v.value = VAL_W'($urandom_range(7, 0));
        return v;
    endfunction

    task automatic send_frame(int len);
        voxel_t v;
        for (int i = 0; i < len; i++) begin
            v = rand_voxel($urandom_range(99) < 80);
            v.last = (i == len - 1);
            send_voxel(v);
        end
    endtask

    // receiver ready with random idling and an optional hold-off
    always @(posedge aclk) begin
        if (hold_rx) begin
            m_tready <= 1'b0;
        end else if (!idle_on) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 18);
        end
    end

    initial begin
        wait (hold_req);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx = 1'b0;
    end

    // result checker
    always @(posedge aclk) begin
        moments_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.index = m_tdata[6:0];
            got.total = m_tdata[48:7];
            got.cz = m_tdata[62:49];
            got.cy = m_tdata[80:63];
            got.cx = m_tdata[98:81];
            got.last = m_tlast;
            regions_seen++;
            if (region_q.size() == 0) begin
                fail_cnt++;
                mism_cnt++;
                if (mism_cnt <= 10)
                    $display("ERROR: unexpected word idx=%0d total=%0d", got.index, got.total);
            end else begin
                want = region_q.pop_front();
                if (got !== want) begin
                    fail_cnt++;
                    mism_cnt++;
                    if (mism_cnt <= 10) begin
                        $display("ERROR: exp idx=%0d tot=%0d cz=%0d cy=%0d cx=%0d last=%0b",
                                 want.index, want.total, want.cz, want.cy, want.cx, want.last);
                        $display("       got idx=%0d tot=%0d cz=%0d cy=%0d cx=%0d last=%0b",
                                 got.index, got.total, got.cz, got.cy, got.cx, got.last);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL labeled_region_centroids");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    dir_row_t dir_tab [N_DIR];

    initial begin
        int unsigned cnt;
        // single-label frames: typed results where the answer is plain
        dir_tab[0]  = '{'{16'd256, 7'd1, 6'd3, 10'd5, 10'd7, 1'b1}, 1'b1,
                        '{7'd1, 42'd256, 14'd768, 18'd1280, 18'd1792, 1'b1}};
        // zero intensity gives zero total and zero centroids
        dir_tab[1]  = '{'{16'd0, 7'd1, 6'd63, 10'd1023, 10'd1023, 1'b1}, 1'b1,
                        '{7'd1, 42'd0, 14'd0, 18'd0, 18'd0, 1'b1}};
        dir_tab[2]  = '{'{16'hffff, 7'd1, 6'd63, 10'd1023, 10'd1023, 1'b1}, 1'b1,
                        '{7'd1, 42'd65535, 14'd16128, 18'd261888, 18'd261888, 1'b1}};
        // unlabeled voxel is dropped
        dir_tab[3]  = '{'{16'd100, 7'd0, 6'd1, 10'd1, 10'd1, 1'b1}, 1'b1,
                        '{7'd1, 42'd0, 14'd0, 18'd0, 18'd0, 1'b1}};
        // labels above the count are dropped
        dir_tab[4]  = '{'{16'd100, 7'd2, 6'd1, 10'd1, 10'd1, 1'b1}, 1'b1,
                        '{7'd1, 42'd0, 14'd0, 18'd0, 18'd0, 1'b1}};
        dir_tab[5]  = '{'{16'hffff, 7'd127, 6'd63, 10'd1023, 10'd1023, 1'b1}, 1'b1,
                        '{7'd1, 42'd0, 14'd0, 18'd0, 18'd0, 1'b1}};
        // multi-voxel frames with rounding, predicted
        dir_tab[6]  = '{'{16'd3, 7'd1, 6'd1, 10'd2, 10'd3, 1'b0}, 1'b0, '{default: 0}};
        dir_tab[7]  = '{'{16'd0, 7'd127, 6'd42, 10'd682, 10'd341, 1'b0}, 1'b0, '{default: 0}};
        dir_tab[8]  = '{'{16'd1, 7'd1, 6'd0, 10'd0, 10'd1, 1'b1}, 1'b0, '{default: 0}};
        dir_tab[9]  = '{'{16'hffff, 7'd1, 6'd0, 10'd0, 10'd0, 1'b0}, 1'b0, '{default: 0}};
        dir_tab[10] = '{'{16'd1, 7'd1, 6'd63, 10'd1023, 10'd1023, 1'b0}, 1'b0, '{default: 0}};
        dir_tab[11] = '{'{16'd2, 7'd1, 6'd21, 10'd341, 10'd682, 1'b1}, 1'b0, '{default: 0}};

        clear_moments();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part with one label reported per frame
        write_label_count(1);
        foreach (dir_tab[i]) send_voxel(dir_tab[i].vox, dir_tab[i].typed, dir_tab[i].res);
        drain();

        // count zero: readout yields nothing but still clears
        write_label_count(0);
        send_frame(6);
        drain();

        // count at or above the table size reports all labels
        write_label_count(127);
        send_frame(30);
        drain();
        write_label_count(64);
        send_frame(40);
        drain();

        // random phases; one without idling, one with a receiver hold-off
        cnt = 0;
        while (voxels_sent < RANDOM_VOXELS - 20) begin
            write_label_count(cnt == 5 ? 64 : $urandom_range(12, 1));
            idle_on = (cnt != 2);
            if (cnt == 3) hold_req = 1'b1;
            repeat (3) send_frame($urandom_range(20, 1));
            if (cnt % 2 == 0) drain();
            else begin
                // sender pause until every result is back
                stop_sending();
                wait (region_q.size() == 0);
                repeat (DRAIN_CYCLES) @(posedge aclk);
            end
            cnt++;
        end
        idle_on = 1'b1;
        write_label_count(0);
        send_frame(5);
        drain();

        $display("Run: %0d voxels in %0d volumes, %0d region words checked, counts 0 to 127.",
                 voxels_sent, frames_sent, regions_seen);
        if (fail_cnt == 0 && region_q.size() == 0) begin
            $display("PASS labeled_region_centroids");
        end else begin
            $display("%0d mismatches, %0d words still expected", fail_cnt, region_q.size());
            $display("FAIL labeled_region_centroids");
        end
        $finish;
    end

endmodule
`default_nettype wire
